>>> design/mfp_pkg.sv
// Package for the message frame parser: field widths, codes and the magic table.
package mfp_pkg;

   // Field widths
   localparam int BYTE_W   = 8;
   localparam int ROLE_W   = 2;
   localparam int STATUS_W = 2;
   localparam int PORT_W   = 16;
   localparam int POS_W    = 16;
   localparam int COUNT_W  = 16;

   // Configuration port
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;
   localparam logic [CSR_INDEX_W-1:0] CSR_NAME_LIMIT    = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PAYLOAD_LIMIT = 2'd1;

   localparam logic [BYTE_W-1:0]  NAME_LIMIT_RESET    = 8'd63;
   localparam logic [COUNT_W-1:0] PAYLOAD_LIMIT_RESET = 16'd1023;

   // Shortest frame that can carry a full header
   localparam int MIN_HEADER = 8;

   // Byte role tags
   localparam logic [ROLE_W-1:0] ROLE_HEADER  = 2'd0;
   localparam logic [ROLE_W-1:0] ROLE_NAME    = 2'd1;
   localparam logic [ROLE_W-1:0] ROLE_PAYLOAD = 2'd2;
   localparam logic [ROLE_W-1:0] ROLE_TRUNC   = 2'd3;

   // Frame status codes
   localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_SHORT     = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_BAD_MAGIC = 2'd2;

   typedef logic [BYTE_W-1:0] byte_type;

   // Expected magic byte at each of the first four positions
   function automatic byte_type magic_byte(input logic [1:0] idx);
      byte_type value;
      unique case (idx)
         2'd0: value = 8'h4e;
         2'd1: value = 8'h4d;
         2'd2: value = 8'h4c;
         2'd3: value = 8'h01;
         default: value = 8'h00;
      endcase
      return value;
   endfunction

endpackage

>>> design/mfp_channels.sv
// Valid/ready channel interfaces for the frame parser: request, response and register write.
interface mfp_req_if;
   import mfp_pkg::*;
   logic                valid;
   logic                ready;
   logic [BYTE_W-1:0]   data_byte;
   logic                last_byte;
   modport source (output valid, data_byte, last_byte, input ready);
   modport sink   (input valid, data_byte, last_byte, output ready);
endinterface

interface mfp_rsp_if;
   import mfp_pkg::*;
   logic                valid;
   logic                ready;
   logic [BYTE_W-1:0]   byte_value;
   logic [ROLE_W-1:0]   byte_role;
   logic                frame_done;
   logic [STATUS_W-1:0] status;
   logic [BYTE_W-1:0]   msg_type;
   logic [BYTE_W-1:0]   name_length;
   logic [PORT_W-1:0]   port;
   logic [COUNT_W-1:0]  payload_count;
   modport source (output valid, byte_value, byte_role, frame_done, status, msg_type,
                   name_length, port, payload_count, input ready);
   modport sink   (input valid, byte_value, byte_role, frame_done, status, msg_type,
                   name_length, port, payload_count, output ready);
endinterface

interface mfp_csr_if;
   import mfp_pkg::*;
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [CSR_DATA_W-1:0]  data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

>>> design/message_frame_parser.sv
// Top level of the message frame parser: per-byte frame decode with a registered result.
//
//  Channel  Dir  Payload                                          Accepted when
//  req      in   data_byte, last_byte                             req.valid & req.ready
//  rsp      out  byte_value, byte_role, frame_done, status,       rsp.valid & rsp.ready
//                msg_type, name_length, port, payload_count
//  csr      in   index (0 name_limit, 1 payload_limit), data      csr.valid & csr.ready
//
// One byte per cycle unless stalled: each accepted item is decoded from the frame state
// in the cycle it arrives; its result is in the output register on the next cycle.
// req.ready is high while the output register is empty or being emptied, so a stalled
// consumer holds the result and stops intake. csr.ready is always high.
// Reset (synchronous) clears frame state and sets the limits to 63 and 1023.
module message_frame_parser (
   input  logic          clock,
   input  logic          reset,
   mfp_req_if.sink       req,
   mfp_rsp_if.source     rsp,
   mfp_csr_if.sink       csr
);
   import mfp_pkg::*;

   localparam int EXT_W = POS_W + 1;

   // Configuration registers
   logic [BYTE_W-1:0]  name_limit_ff;
   logic [COUNT_W-1:0] payload_limit_ff;

   // Frame state
   logic [POS_W-1:0]   pos_ff,       pos_in;
   logic               magic_bad_ff, magic_bad_in;
   logic [BYTE_W-1:0]  type_ff,      type_in;
   logic [BYTE_W-1:0]  decl_len_ff,  decl_len_in;
   logic [PORT_W-1:0]  port_ff,      port_in;
   logic [COUNT_W-1:0] kept_ff,      kept_in;

   // Result register
   logic                rsp_valid_ff,  rsp_valid_in;
   logic [BYTE_W-1:0]   value_ff;
   logic [ROLE_W-1:0]   role_ff,       role_in;
   logic                done_ff;
   logic [STATUS_W-1:0] status_ff,     status_in;
   logic [BYTE_W-1:0]   out_type_ff,   out_type_in;
   logic [BYTE_W-1:0]   out_nl_ff,     out_nl_in;
   logic [PORT_W-1:0]   out_port_ff,   out_port_in;
   logic [COUNT_W-1:0]  out_count_ff,  out_count_in;

   logic               accept;
   logic [EXT_W-1:0]   pos_ext;
   logic [EXT_W-1:0]   name_end;
   logic [BYTE_W-1:0]  name_index;
   logic               final_status_ok;

   assign accept    = req.valid && req.ready;
   assign req.ready = !rsp_valid_ff || rsp.ready;
   assign csr.ready = 1'b1;

   assign pos_ext    = {1'b0, pos_ff};
   assign name_end   = EXT_W'(decl_len_ff) + EXT_W'(6);
   assign name_index = BYTE_W'(pos_ff - POS_W'(6));

   // Decode of one byte against the frame state
   always_comb begin
      magic_bad_in = magic_bad_ff;
      type_in      = type_ff;
      decl_len_in  = decl_len_ff;
      port_in      = port_ff;
      kept_in      = kept_ff;
      role_in      = ROLE_HEADER;

      if (pos_ff < POS_W'(4)) begin
         if (req.data_byte != magic_byte(pos_ff[1:0])) begin
            magic_bad_in = 1'b1;
         end
      end else if (pos_ff == POS_W'(4)) begin
         type_in = req.data_byte;
      end else if (pos_ff == POS_W'(5)) begin
         decl_len_in = req.data_byte;
      end else if (pos_ext < name_end) begin
         role_in = (name_index < name_limit_ff) ? ROLE_NAME : ROLE_TRUNC;
      end else if (pos_ext == name_end) begin
         port_in = {req.data_byte, port_ff[BYTE_W-1:0]};
      end else if (pos_ext == name_end + EXT_W'(1)) begin
         port_in = {port_ff[PORT_W-1:BYTE_W], req.data_byte};
      end else begin
         if (kept_ff < payload_limit_ff) begin
            kept_in = kept_ff + COUNT_W'(1);
            role_in = ROLE_PAYLOAD;
         end else begin
            role_in = ROLE_TRUNC;
         end
      end

      // A failed magic discards this byte and the rest of the frame
      if (magic_bad_in) begin
         role_in = ROLE_HEADER;
      end
   end

   // Frame status on the last byte, header fields only for a good frame
   always_comb begin
      status_in = STATUS_OK;
      if (req.last_byte) begin
         priority if (pos_ff < POS_W'(MIN_HEADER - 1)) begin
            status_in = STATUS_SHORT;
         end else if (magic_bad_in) begin
            status_in = STATUS_BAD_MAGIC;
         end else if (pos_ext < name_end + EXT_W'(1)) begin
            status_in = STATUS_SHORT;
         end else begin
            status_in = STATUS_OK;
         end
      end
      final_status_ok = req.last_byte && (status_in == STATUS_OK);
      out_type_in  = final_status_ok ? type_in     : '0;
      out_nl_in    = final_status_ok ? decl_len_in : '0;
      out_port_in  = final_status_ok ? port_in     : '0;
      out_count_in = final_status_ok ? kept_in     : '0;
   end

   // Next byte position, saturating; cleared after the last byte
   always_comb begin
      if (req.last_byte) begin
         pos_in = '0;
      end else if (pos_ff != '1) begin
         pos_in = pos_ff + POS_W'(1);
      end else begin
         pos_in = pos_ff;
      end
   end

   assign rsp_valid_in = accept || (rsp_valid_ff && !rsp.ready);

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         name_limit_ff    <= NAME_LIMIT_RESET;
         payload_limit_ff <= PAYLOAD_LIMIT_RESET;
      end else if (csr.valid && csr.ready) begin
         unique case (csr.index)
            CSR_NAME_LIMIT:    name_limit_ff    <= csr.data[BYTE_W-1:0];
            CSR_PAYLOAD_LIMIT: payload_limit_ff <= csr.data[COUNT_W-1:0];
            default: ;
         endcase
      end
   end

   // Frame state update
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         magic_bad_ff <= 1'b0;
         type_ff      <= '0;
         decl_len_ff  <= '0;
         port_ff      <= '0;
         kept_ff      <= '0;
      end else if (accept) begin
         pos_ff <= pos_in;
         if (req.last_byte) begin
            magic_bad_ff <= 1'b0;
            type_ff      <= '0;
            decl_len_ff  <= '0;
            port_ff      <= '0;
            kept_ff      <= '0;
         end else begin
            magic_bad_ff <= magic_bad_in;
            type_ff      <= type_in;
            decl_len_ff  <= decl_len_in;
            port_ff      <= port_in;
            kept_ff      <= kept_in;
         end
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         value_ff     <= req.data_byte;
         role_ff      <= role_in;
         done_ff      <= req.last_byte;
         status_ff    <= status_in;
         out_type_ff  <= out_type_in;
         out_nl_ff    <= out_nl_in;
         out_port_ff  <= out_port_in;
         out_count_ff <= out_count_in;
      end
   end

   assign rsp.valid         = rsp_valid_ff;
   assign rsp.byte_value    = value_ff;
   assign rsp.byte_role     = role_ff;
   assign rsp.frame_done    = done_ff;
   assign rsp.status        = status_ff;
   assign rsp.msg_type      = out_type_ff;
   assign rsp.name_length   = out_nl_ff;
   assign rsp.port          = out_port_ff;
   assign rsp.payload_count = out_count_ff;

endmodule

>>> design/mfp_checker.sv
// Port-level checker for the message frame parser and its bind to the top level.
module mfp_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input logic [mfp_pkg::BYTE_W-1:0]     rsp_byte_value,
   input logic                           rsp_frame_done,
   input logic [mfp_pkg::STATUS_W-1:0]   rsp_status,
   input logic [mfp_pkg::BYTE_W-1:0]     rsp_msg_type,
   input logic [mfp_pkg::BYTE_W-1:0]     rsp_name_length,
   input logic [mfp_pkg::PORT_W-1:0]     rsp_port,
   input logic [mfp_pkg::COUNT_W-1:0]    rsp_payload_count
);
   import mfp_pkg::*;

   // A held result stays offered with its byte value unchanged
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_byte_value))
      else $error("rsp item dropped or changed while stalled");

   // Mid-frame items carry no frame summary
   a_mid_frame_clear: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_frame_done |-> rsp_status == STATUS_OK && rsp_msg_type == '0
         && rsp_name_length == '0 && rsp_port == '0 && rsp_payload_count == '0)
      else $error("frame summary shown before the last byte");

   // A failed frame reports zero header fields
   a_fail_clear: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frame_done && rsp_status != STATUS_OK |-> rsp_msg_type == '0
         && rsp_name_length == '0 && rsp_port == '0 && rsp_payload_count == '0)
      else $error("failed frame reports header fields");

   // Only defined status codes appear
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status == STATUS_OK || rsp_status == STATUS_SHORT
         || rsp_status == STATUS_BAD_MAGIC)
      else $error("undefined status code");

endmodule

bind message_frame_parser mfp_checker u_mfp_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp.valid),
   .rsp_ready         (rsp.ready),
   .rsp_byte_value    (rsp.byte_value),
   .rsp_frame_done    (rsp.frame_done),
   .rsp_status        (rsp.status),
   .rsp_msg_type      (rsp.msg_type),
   .rsp_name_length   (rsp.name_length),
   .rsp_port          (rsp.port),
   .rsp_payload_count (rsp.payload_count)
);
